### sv/isc_pkg.sv
// Shared types and constants for the idle standby controller.
`default_nettype none

package isc_pkg;

    // Number of animation patterns in the rotation
    localparam int unsigned PATTERN_COUNT = 4;
    localparam int unsigned PATTERN_W = (PATTERN_COUNT > 1) ? $clog2(PATTERN_COUNT) : 1;

    localparam int unsigned TIME_W  = 32;
    localparam int unsigned FRAME_W = 16;
    localparam int unsigned DEPTH_W = 16;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    localparam logic [TIME_W-1:0]  IDLE_TIMEOUT_RESET   = 32'd60000;
    localparam logic [TIME_W-1:0]  ANIM_CYCLE_RESET     = 32'd120000;
    localparam logic [FRAME_W-1:0] FRAME_INTERVAL_RESET = 16'd40;
    localparam logic [DEPTH_W-1:0] HALL_WAKE_RESET      = 16'd150;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IDLE_TIMEOUT   = 2'd0,
        CFG_ANIM_CYCLE     = 2'd1,
        CFG_FRAME_INTERVAL = 2'd2,
        CFG_HALL_WAKE      = 2'd3
    } cfg_index_t;

    // Mode change codes in the result
    typedef enum logic [1:0] {
        MODE_NONE  = 2'd0,
        MODE_ENTER = 2'd1,
        MODE_EXIT  = 2'd2
    } mode_change_t;

    typedef struct packed {
        logic [TIME_W-1:0]  idle_timeout_ms;
        logic [TIME_W-1:0]  animation_cycle_ms;
        logic [FRAME_W-1:0] frame_interval_ms;
        logic [DEPTH_W-1:0] hall_wake_depth;
    } cfg_regs_t;

    typedef struct packed {
        logic [TIME_W-1:0]  now_ms;
        logic               user_active;
        logic [DEPTH_W-1:0] peak_depth;
    } scan_t;

    typedef struct packed {
        logic         standby_on;
        logic         render_strobe;
        logic [1:0]   pattern_select;
        mode_change_t mode_change;
    } result_t;

endpackage

`default_nettype wire

### sv/isc_cfg.sv
// Configuration register file for the idle standby controller.
`default_nettype none

module isc_cfg
    import isc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_regs_t                   cfg_regs
);

    cfg_regs_t regs_reg;

    assign cfg_ready = 1'b1;
    assign cfg_regs  = regs_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.idle_timeout_ms    <= IDLE_TIMEOUT_RESET;
            regs_reg.animation_cycle_ms <= ANIM_CYCLE_RESET;
            regs_reg.frame_interval_ms  <= FRAME_INTERVAL_RESET;
            regs_reg.hall_wake_depth    <= HALL_WAKE_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_IDLE_TIMEOUT:   regs_reg.idle_timeout_ms    <= cfg_data;
                CFG_ANIM_CYCLE:     regs_reg.animation_cycle_ms <= cfg_data;
                CFG_FRAME_INTERVAL: regs_reg.frame_interval_ms  <= cfg_data[FRAME_W-1:0];
                CFG_HALL_WAKE:      regs_reg.hall_wake_depth    <= cfg_data[DEPTH_W-1:0];
                default:            ;
            endcase
        end
    end

endmodule

`default_nettype wire

### sv/isc_core.sv
// Standby state, timers and per-scan decision logic.
`default_nettype none

module isc_core
    import isc_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step,
    input  wire scan_t     scan,
    input  wire cfg_regs_t cfg_regs,
    output result_t        result
);

    logic                 standby_reg, standby_next;
    logic [TIME_W-1:0]    activity_time_reg, activity_time_next;
    logic [TIME_W-1:0]    frame_time_reg, frame_time_next;
    logic [TIME_W-1:0]    switch_time_reg, switch_time_next;
    logic [PATTERN_W-1:0] pattern_reg, pattern_next;

    logic [TIME_W-1:0]    idle_span;
    logic [TIME_W-1:0]    switch_span;
    logic [TIME_W-1:0]    frame_span;
    logic [PATTERN_W+1:0] pattern_ext;
    logic                 strobe;
    mode_change_t         change;

    assign idle_span   = scan.now_ms - activity_time_reg;
    assign switch_span = scan.now_ms - switch_time_reg;
    assign frame_span  = scan.now_ms - frame_time_reg;

    always_comb
    begin
        standby_next       = standby_reg;
        activity_time_next = activity_time_reg;
        frame_time_next    = frame_time_reg;
        switch_time_next   = switch_time_reg;
        pattern_next       = pattern_reg;
        strobe             = 1'b0;
        change             = MODE_NONE;

        if (scan.user_active)
        begin
            activity_time_next = scan.now_ms;
            if (standby_reg)
            begin
                standby_next = 1'b0;
                change       = MODE_EXIT;
            end
        end
        else if (!standby_reg)
        begin
            if (idle_span >= cfg_regs.idle_timeout_ms)
            begin
                // Restart the rotation and clear the frame timer
                standby_next     = 1'b1;
                pattern_next     = '0;
                switch_time_next = scan.now_ms;
                frame_time_next  = '0;
                change           = MODE_ENTER;
            end
        end
        else if (scan.peak_depth >= cfg_regs.hall_wake_depth)
        begin
            activity_time_next = scan.now_ms;
            standby_next       = 1'b0;
            change             = MODE_EXIT;
        end
        else
        begin
            if (switch_span >= cfg_regs.animation_cycle_ms)
            begin
                if (pattern_reg == PATTERN_W'(PATTERN_COUNT - 1))
                    pattern_next = '0;
                else
                    pattern_next = pattern_reg + PATTERN_W'(1);
                switch_time_next = scan.now_ms;
            end
            if (frame_span >= {{(TIME_W-FRAME_W){1'b0}}, cfg_regs.frame_interval_ms})
            begin
                strobe          = 1'b1;
                frame_time_next = scan.now_ms;
            end
        end
    end

    assign pattern_ext = {2'b00, pattern_next};

    assign result.standby_on     = standby_next;
    assign result.render_strobe  = strobe;
    assign result.pattern_select = pattern_ext[1:0];
    assign result.mode_change    = change;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            standby_reg       <= 1'b0;
            activity_time_reg <= '0;
            frame_time_reg    <= '0;
            switch_time_reg   <= '0;
            pattern_reg       <= '0;
        end
        else if (step)
        begin
            standby_reg       <= standby_next;
            activity_time_reg <= activity_time_next;
            frame_time_reg    <= frame_time_next;
            switch_time_reg   <= switch_time_next;
            pattern_reg       <= pattern_next;
        end
    end

endmodule

`default_nettype wire

### sv/idle_standby_controller.sv
// Idle standby controller: scan register, decision core and result register.
// A request accepted into the scan register passes through the decision core into the
// result register, which drives m_tvalid; a stalled result holds the scan register.
// Throughput: one scan per cycle while the result side keeps m_tready high;
// the scan register and the result register each hold one request.
// Reset clears core state and both valid flags and restores the config defaults.
`default_nettype none

module idle_standby_controller
    import isc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // Scan stream
    input  wire logic                   s_tvalid,
    output logic                        s_tready,
    input  wire logic [47:0]            s_tdata,  // now_ms[31:0], peak_depth[47:32]
    input  wire logic                   s_tuser,  // user_active
    // Result stream
    output logic                        m_tvalid,
    input  wire logic                   m_tready,
    output logic [7:0]                  m_tdata,  // standby_on[0], render_strobe[1],
                                                  // pattern_select[3:2], mode_change[5:4]
    // Configuration writes
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_regs_t cfg_regs;
    scan_t     scan_reg;
    logic      scan_valid_reg;
    result_t   result;
    result_t   result_reg;
    logic      result_valid_reg;
    logic      advance;

    isc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg_regs  (cfg_regs)
    );

    // Move the held scan on when the result register is free or being drained
    assign advance  = scan_valid_reg && (!result_valid_reg || m_tready);
    assign s_tready = !scan_valid_reg || advance;

    isc_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (advance),
        .scan     (scan_reg),
        .cfg_regs (cfg_regs),
        .result   (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
                scan_valid_reg <= s_tvalid;
            if (advance)
                result_valid_reg <= 1'b1;
            else if (m_tready)
                result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            scan_reg.now_ms      <= s_tdata[31:0];
            scan_reg.peak_depth  <= s_tdata[47:32];
            scan_reg.user_active <= s_tuser;
        end
        if (advance)
            result_reg <= result;
    end

    assign m_tvalid = result_valid_reg;
    assign m_tdata  = {2'b00, result_reg.mode_change, result_reg.pattern_select,
                       result_reg.render_strobe, result_reg.standby_on};

    // A frame is only drawn in standby
    a_strobe_in_standby: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && result_reg.render_strobe |-> result_reg.standby_on)
        else $error("render strobe outside standby");

    // Entering standby leaves standby on, pattern 0 and no frame
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && (result_reg.mode_change == MODE_ENTER) |->
            result_reg.standby_on && !result_reg.render_strobe &&
            (result_reg.pattern_select == 2'd0))
        else $error("inconsistent standby entry");

    // Leaving standby leaves standby off
    a_exit: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && (result_reg.mode_change == MODE_EXIT) |->
            !result_reg.standby_on && !result_reg.render_strobe)
        else $error("inconsistent standby exit");

    // A stalled result holds until taken
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid_reg && !m_tready |=> result_valid_reg && $stable(result_reg))
        else $error("result changed while stalled");

endmodule

`default_nettype wire

### tb/sv/idle_standby_controller_tb.sv
// Self-checking testbench for the idle standby controller: scan stream in, result stream out.
`timescale 1ns / 100ps

module idle_standby_controller_tb;
    import isc_pkg::*;

    // Holds the controller's expected state and the results still owed by the block
    class standby_scoreboard;
        cfg_regs_t   regs;
        logic        in_standby;
        logic [31:0] last_activity;
        logic [31:0] last_frame;
        logic [31:0] pattern_switch;
        int unsigned pattern_idx;
        result_t     pending[$];
        int unsigned errors;
        int unsigned scans;
        int unsigned checked;
        int unsigned entries;
        int unsigned exits;
        int unsigned strobes;
        int unsigned rotations;
        int unsigned settings;

        function new();
            regs.idle_timeout_ms    = IDLE_TIMEOUT_RESET;
            regs.animation_cycle_ms = ANIM_CYCLE_RESET;
            regs.frame_interval_ms  = FRAME_INTERVAL_RESET;
            regs.hall_wake_depth    = HALL_WAKE_RESET;
            in_standby     = 1'b0;
            last_activity  = '0;
            last_frame     = '0;
            pattern_switch = '0;
            pattern_idx    = 0;
            errors = 0; scans = 0; checked = 0; entries = 0;
            exits = 0; strobes = 0; rotations = 0; settings = 1;
        endfunction

        function void write_register(cfg_index_t idx, logic [31:0] data);
            case (idx)
                CFG_IDLE_TIMEOUT:   regs.idle_timeout_ms    = data;
                CFG_ANIM_CYCLE:     regs.animation_cycle_ms = data;
                CFG_FRAME_INTERVAL: regs.frame_interval_ms  = data[15:0];
                CFG_HALL_WAKE:      regs.hall_wake_depth    = data[15:0];
                default: ;
            endcase
        endfunction

        // Advance the expected state by one scan and queue the result it owes
        function void note_scan(scan_t s);
            result_t     r;
            logic [31:0] idle_span;
            logic [31:0] pattern_age;
            logic [31:0] frame_age;
            r.render_strobe = 1'b0;
            r.mode_change   = MODE_NONE;
            idle_span   = s.now_ms - last_activity;
            pattern_age = s.now_ms - pattern_switch;
            frame_age   = s.now_ms - last_frame;
            if (s.user_active) begin
                last_activity = s.now_ms;
                if (in_standby) begin
                    in_standby    = 1'b0;
                    r.mode_change = MODE_EXIT;
                end
            end
            else if (!in_standby) begin
                if (idle_span >= regs.idle_timeout_ms) begin
                    in_standby     = 1'b1;
                    pattern_idx    = 0;
                    pattern_switch = s.now_ms;
                    last_frame     = '0;
                    r.mode_change  = MODE_ENTER;
                end
            end
            else if (s.peak_depth >= regs.hall_wake_depth) begin
                last_activity = s.now_ms;
                in_standby    = 1'b0;
                r.mode_change = MODE_EXIT;
            end
            else begin
                if (pattern_age >= regs.animation_cycle_ms) begin
                    pattern_idx    = (pattern_idx + 1) % PATTERN_COUNT;
                    pattern_switch = s.now_ms;
                    rotations++;
                end
                if (frame_age >= {16'd0, regs.frame_interval_ms}) begin
                    r.render_strobe = 1'b1;
                    last_frame      = s.now_ms;
                    strobes++;
                end
            end
            if (r.mode_change == MODE_ENTER) entries++;
            if (r.mode_change == MODE_EXIT) exits++;
            r.standby_on     = in_standby;
            r.pattern_select = pattern_idx[1:0];
            pending.push_back(r);
            scans++;
        endfunction

        function void check_result(logic [7:0] word);
            result_t want;
            if (pending.size() == 0) begin
                $error("result 0x%02h arrived with no scan outstanding", word);
                errors++;
                return;
            end
            want = pending.pop_front();
            checked++;
            if (word[0] !== want.standby_on) begin
                $error("standby_on: expected %0d, got %0d", want.standby_on, word[0]);
                errors++;
            end
            if (word[1] !== want.render_strobe) begin
                $error("render_strobe: expected %0d, got %0d", want.render_strobe, word[1]);
                errors++;
            end
            if (word[3:2] !== want.pattern_select) begin
                $error("pattern_select: expected %0d, got %0d", want.pattern_select, word[3:2]);
                errors++;
            end
            if (word[5:4] !== want.mode_change) begin
                $error("mode_change: expected %0d, got %0d", want.mode_change, word[5:4]);
                errors++;
            end
        endfunction
    endclass

    logic                   clk;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [47:0]            s_tdata;   // now_ms[31:0], peak_depth[47:32]
    logic                   s_tuser;   // user_active
    logic                   m_tvalid;
    logic                   m_tready;
    logic [7:0]             m_tdata;   // standby_on[0], render_strobe[1],
                                       // pattern_select[3:2], mode_change[5:4]
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    standby_scoreboard sb = new();

    bit          sender_gaps;
    bit          receiver_stalls;
    bit          hold_off_pending;
    logic [31:0] scan_clock;
    logic [15:0] wake_depth;

    idle_standby_controller uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    // Result side: random stall bursts plus one long hold-off on request
    initial
    begin
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        m_tready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_pending)
            begin
                hold_off_pending = 1'b0;
                hold_left = 120;
            end
            if (hold_left > 0)
            begin
                m_tready = 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else if (receiver_stalls && $urandom_range(0, 5) == 0)
            begin
                m_tready   = 1'b0;
                stall_left = $urandom_range(1, 9) - 1;
            end
            else
            begin
                m_tready = 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    task automatic send_scan(logic [31:0] now, logic active, logic [15:0] depth);
        scan_t s;
        int    gap;
        s.now_ms      = now;
        s.user_active = active;
        s.peak_depth  = depth;
        if (sender_gaps && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 9);
            @(negedge clk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata  = {depth, now};
        s_tuser  = active;
        do @(posedge clk); while (!s_tready);
        sb.note_scan(s);
    endtask

    task automatic write_register(cfg_index_t idx, logic [31:0] data);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        do @(posedge clk); while (!cfg_ready);
        sb.write_register(idx, data);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Drop the request, let every owed result drain, then settle before a write
    task automatic drain;
        @(negedge clk);
        s_tvalid = 1'b0;
        while (sb.pending.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic load_settings(logic [31:0] timeout, logic [31:0] cycle,
                                 logic [15:0] interval, logic [15:0] depth);
        write_register(CFG_IDLE_TIMEOUT, timeout);
        write_register(CFG_ANIM_CYCLE, cycle);
        write_register(CFG_FRAME_INTERVAL, {16'd0, interval});
        write_register(CFG_HALL_WAKE, {16'd0, depth});
        wake_depth = depth;
        sb.settings++;
    endtask

    // Idle stretches broken by short bursts of activity, plus some wild scans
    task automatic run_scans(int count, int step_max);
        int          i;
        int          idle_run;
        int          active_run;
        int          step;
        logic [15:0] depth;
        idle_run   = $urandom_range(3, 60);
        active_run = 0;
        for (i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 99) < 8)
            begin
                send_scan($urandom, 1'($urandom_range(0, 1)), 16'($urandom));
            end
            else
            begin
                if ($urandom_range(0, 15) == 0)
                    step = $urandom_range(0, step_max * 20);
                else
                    step = $urandom_range(0, step_max);
                scan_clock = scan_clock + step;
                if (active_run > 0)
                begin
                    active_run--;
                    if (active_run == 0)
                        idle_run = $urandom_range(3, 60);
                    send_scan(scan_clock, 1'b1, 16'($urandom));
                end
                else
                begin
                    if ($urandom_range(0, 19) == 0)
                        depth = 16'($urandom_range(wake_depth, 16'hFFFF));
                    else if (wake_depth == 0)
                        depth = '0;
                    else
                        depth = 16'($urandom_range(0, wake_depth - 1));
                    idle_run--;
                    if (idle_run <= 0)
                        active_run = $urandom_range(1, 4);
                    send_scan(scan_clock, 1'b0, depth);
                end
            end
        end
    endtask

    initial
    begin
        int          phase;
        int          step_max;
        logic [31:0] timeout;
        logic [31:0] cycle;
        logic [31:0] interval;
        logic [15:0] depth;
        rst_n            = 1'b0;
        s_tvalid         = 1'b0;
        s_tdata          = '0;
        s_tuser          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_index        = CFG_IDLE_TIMEOUT;
        cfg_data         = '0;
        sender_gaps      = 1'b1;
        receiver_stalls  = 1'b1;
        hold_off_pending = 1'b0;
        scan_clock       = '0;
        wake_depth       = HALL_WAKE_RESET;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: timeout edge, entry scan, frame, rotation, Hall exit, wrap entry and user exit
        send_scan(32'd0, 1'b0, 16'd0);
        send_scan(32'd59999, 1'b0, 16'd0);
        send_scan(32'd60000, 1'b0, 16'd0);
        send_scan(32'd60000, 1'b0, 16'd149);
        send_scan(32'd60010, 1'b0, 16'd0);
        send_scan(32'd180000, 1'b0, 16'd0);
        send_scan(32'd180001, 1'b0, 16'd150);
        send_scan(32'hFFFF_FFFF, 1'b1, 16'hFFFF);
        send_scan(32'd59999, 1'b0, 16'd0);
        send_scan(32'd60000, 1'b1, 16'd0);
        drain();

        // Zero timers: an idle scan enters, later ones rotate and draw until a full-depth Hall exit
        load_settings(32'd0, 32'd0, 16'd0, 16'hFFFF);
        send_scan(32'd60000, 1'b0, 16'd0);
        send_scan(32'd60001, 1'b0, 16'hFFFE);
        send_scan(32'd60001, 1'b0, 16'hFFFE);
        send_scan(32'd60002, 1'b0, 16'hFFFF);
        send_scan(32'd1000, 1'b1, 16'hFFFF);
        drain();

        // Widest timeout across the wrap, then a zero wake depth
        load_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'd0);
        send_scan(32'd998, 1'b0, 16'd0);
        send_scan(32'd999, 1'b0, 16'd0);
        send_scan(32'd999, 1'b0, 16'd0);
        drain();

        for (phase = 0; phase < 12; phase++)
        begin
            step_max = $urandom_range(2, 300);
            timeout  = $urandom_range(0, 12 * step_max);
            cycle    = $urandom_range(0, 20 * step_max);
            interval = $urandom_range(0, 4 * step_max);
            depth    = 16'($urandom_range(20, 1000));
            case ($urandom_range(0, 9))
                0: timeout = '0;
                1: cycle = $urandom;
                2: depth = 16'hFFFF;
                3: interval = 32'h0000_FFFF;
                default: ;
            endcase
            if (phase == 0)
            begin
                step_max = 3;
                timeout = 32'd1; cycle = 32'd1; interval = 32'd1; depth = 16'd1;
            end
            else if (phase == 1)
            begin
                step_max = 200;
                timeout = 32'hFFFF_FFFF; cycle = 32'hFFFF_FFFF;
                interval = 32'h0000_FFFF; depth = 16'hFFFF;
            end
            // Start some phases just short of the wrap of the millisecond count
            scan_clock = ($urandom_range(0, 2) == 0) ? 32'hFFFF_F000 + $urandom_range(0, 4000)
                                                     : $urandom;
            if (interval > 32'h0000_FFFF)
                interval = 32'h0000_FFFF;
            load_settings(timeout, cycle, interval[15:0], depth);
            sender_gaps     = (phase < 10) && (phase != 4);
            receiver_stalls = (phase < 10);
            if (phase == 4)
                hold_off_pending = 1'b1;
            run_scans(140, step_max);
            drain();
        end

        if (sb.pending.size() != 0)
        begin
            $error("%0d expected results never arrived", sb.pending.size());
            sb.errors++;
        end
        $display("Checked %0d of %0d scans under %0d register settings,",
                 sb.checked, sb.scans, sb.settings);
        $display("seeing %0d standby entries, %0d exits, %0d frames and %0d pattern rotations.",
                 sb.entries, sb.exits, sb.strobes, sb.rotations);
        if (sb.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
